// ===== design/srfr_pkg.sv =====
// Shared types and constants for the servo bus reply frame receiver.
package srfr_pkg;

  // Item operation codes carried in the input tuser field.
  localparam logic [1:0] OP_TX_BYTE  = 2'd0;
  localparam logic [1:0] OP_RX_BYTE  = 2'd1;
  localparam logic [1:0] OP_DEADLINE = 2'd2;

  // Header byte of every frame on the bus.
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // Session outcome codes.
  localparam logic OUTCOME_OK   = 1'b0;
  localparam logic OUTCOME_FAIL = 1'b1;

  // One result item as produced when a session ends.
  typedef struct packed {
    logic       valid;
    logic       outcome;
    logic [7:0] error_status;
    logic [7:0] param_first;
    logic [7:0] param_second;
  } result_t;

endpackage

// ===== design/srfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module srfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read at the written address returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/srfr_core.sv =====
// Echo store and reply frame parser: hunts the header, checks the frame and ends sessions.
module srfr_core #(
  parameter int MAX_FRAME  = 20,
  parameter int ECHO_DEPTH = 16,
  parameter int MAX_SKIPS  = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                item_valid,
  input  logic [1:0]          operation,
  input  logic [7:0]          data_byte,
  input  logic                first_of_frame,
  input  logic [1:0]          param_count,
  output srfr_pkg::result_t   result
);

  localparam int AW = $clog2(ECHO_DEPTH);
  localparam int LW = $clog2(ECHO_DEPTH + 1);
  localparam int PW = $clog2(MAX_FRAME);
  localparam int CW = ((PW > LW) ? PW : LW) + 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME - 4);

  // Configuration and session state.
  logic [7:0]    servo_id;
  logic [LW-1:0] echo_length, echo_length_next;
  logic          hdr0_ff, hdr1_ff, hdr0_ff_next, hdr1_ff_next;
  logic          session_active, session_active_next;
  logic [1:0]    header_run, header_run_next;
  logic [PW-1:0] frame_position, frame_position_next;
  logic [PW-1:0] frame_length, frame_length_next;
  logic [7:0]    running_sum, running_sum_next;
  logic          echo_match, echo_match_next;
  logic [1:0]    skipped_frames, skipped_frames_next;
  logic [7:0]    cap_id, cap_err, cap_p1, cap_p2;
  logic [7:0]    cap_id_next, cap_err_next, cap_p1_next, cap_p2_next;
  logic [1:0]    wanted_count, wanted_count_next;

  // Echo memory ports and read forwarding.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_q, echo_byte;
  logic          fwd_hit;
  logic [7:0]    fwd_data;

  srfr_pkg::result_t result_next;

  // Frame decode helpers.
  logic [1:0]    hr_inc;
  logic [PW-1:0] last_pos;
  logic          byte_is_echo;
  logic          match_upd;
  logic          is_echo, ok_frame;
  logic [1:0]    skip_inc;
  logic [LW-1:0] wr_pos;

  srfr_ram #(
    .WIDTH(8),
    .DEPTH(ECHO_DEPTH)
  ) u_echo_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(data_byte),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  // The byte stored at the current frame position, with a same-cycle write bypassed.
  assign echo_byte = fwd_hit ? fwd_data : ram_q;

  always_comb begin
    echo_length_next    = echo_length;
    hdr0_ff_next        = hdr0_ff;
    hdr1_ff_next        = hdr1_ff;
    session_active_next = session_active;
    header_run_next     = header_run;
    frame_position_next = frame_position;
    frame_length_next   = frame_length;
    running_sum_next    = running_sum;
    echo_match_next     = echo_match;
    skipped_frames_next = skipped_frames;
    cap_id_next         = cap_id;
    cap_err_next        = cap_err;
    cap_p1_next         = cap_p1;
    cap_p2_next         = cap_p2;
    wanted_count_next   = wanted_count;
    result_next         = '0;
    ram_we              = 1'b0;
    ram_waddr           = '0;
    wr_pos              = echo_length;

    hr_inc    = (header_run < 2'd2) ? header_run + 2'd1 : header_run;
    last_pos  = PW'(frame_length + PW'(3));
    byte_is_echo = (CW'(frame_position) < CW'(echo_length)) &&
                   (CW'(frame_position) < CW'(ECHO_DEPTH)) &&
                   (echo_byte == data_byte);
    match_upd = echo_match & byte_is_echo;
    is_echo   = match_upd && ((CW'(frame_length) + CW'(4)) == CW'(echo_length));
    ok_frame  = !is_echo && (cap_id == servo_id) && (~running_sum == data_byte);
    skip_inc  = (skipped_frames < 2'd3) ? skipped_frames + 2'd1 : skipped_frames;

    if (item_valid) begin
      case (operation)
        srfr_pkg::OP_TX_BYTE: begin
          // A first byte opens a new session and restarts the echo record.
          if (first_of_frame) begin
            wr_pos              = '0;
            session_active_next = 1'b1;
            skipped_frames_next = 2'd0;
            wanted_count_next   = (param_count > 2'd2) ? 2'd2 : param_count;
            header_run_next     = 2'd0;
            frame_position_next = '0;
            frame_length_next   = '0;
            running_sum_next    = 8'd0;
            echo_match_next     = 1'b1;
            cap_id_next         = 8'd0;
            cap_err_next        = 8'd0;
            cap_p1_next         = 8'd0;
            cap_p2_next         = 8'd0;
          end
          if (CW'(wr_pos) < CW'(ECHO_DEPTH)) begin
            ram_we           = 1'b1;
            ram_waddr        = AW'(wr_pos);
            echo_length_next = wr_pos + LW'(1);
            if (wr_pos == LW'(0)) begin
              hdr0_ff_next = (data_byte == srfr_pkg::HDR_BYTE);
            end
            if (wr_pos == LW'(1)) begin
              hdr1_ff_next = (data_byte == srfr_pkg::HDR_BYTE);
            end
          end else begin
            echo_length_next = wr_pos;
          end
        end
        srfr_pkg::OP_RX_BYTE: begin
          if (session_active) begin
            if (frame_position == PW'(0)) begin
              // Header hunt over a saturating run of header bytes.
              header_run_next = (data_byte == srfr_pkg::HDR_BYTE) ? hr_inc : 2'd0;
              if (header_run_next == 2'd2) begin
                echo_match_next = (echo_length >= LW'(2)) && hdr0_ff && hdr1_ff;
                frame_position_next = PW'(2);
              end
            end else if (frame_position == PW'(2)) begin
              echo_match_next     = match_upd;
              cap_id_next         = data_byte;
              running_sum_next    = data_byte;
              frame_position_next = PW'(3);
            end else if (frame_position == PW'(3)) begin
              echo_match_next = match_upd;
              if (data_byte < 8'd2 || data_byte > MAX_LEN) begin
                result_next.valid   = 1'b1;
                result_next.outcome = srfr_pkg::OUTCOME_FAIL;
              end else begin
                frame_length_next   = PW'(data_byte);
                running_sum_next    = running_sum + data_byte;
                frame_position_next = PW'(4);
              end
            end else if (frame_position < last_pos) begin
              // Body byte: add to the checksum and capture error and parameters.
              echo_match_next  = match_upd;
              running_sum_next = running_sum + data_byte;
              if (frame_position == PW'(4)) begin
                cap_err_next = data_byte;
              end
              if (frame_position == PW'(5)) begin
                cap_p1_next = data_byte;
              end
              if (frame_position == PW'(6)) begin
                cap_p2_next = data_byte;
              end
              frame_position_next = frame_position + PW'(1);
            end else begin
              // Checksum byte closes the frame: accept it or count it as skipped.
              if (ok_frame) begin
                result_next.valid        = 1'b1;
                result_next.outcome      = srfr_pkg::OUTCOME_OK;
                result_next.error_status = cap_err;
                result_next.param_first  =
                  (wanted_count >= 2'd1 && last_pos > PW'(5)) ? cap_p1 : 8'd0;
                result_next.param_second =
                  (wanted_count >= 2'd2 && last_pos > PW'(6)) ? cap_p2 : 8'd0;
              end else begin
                skipped_frames_next = skip_inc;
                if (skip_inc >= 2'(MAX_SKIPS)) begin
                  result_next.valid   = 1'b1;
                  result_next.outcome = srfr_pkg::OUTCOME_FAIL;
                end
              end
              header_run_next     = 2'd0;
              frame_position_next = '0;
              frame_length_next   = '0;
              running_sum_next    = 8'd0;
              echo_match_next     = 1'b1;
              cap_id_next         = 8'd0;
              cap_err_next        = 8'd0;
              cap_p1_next         = 8'd0;
              cap_p2_next         = 8'd0;
            end
          end
        end
        srfr_pkg::OP_DEADLINE: begin
          if (session_active) begin
            result_next.valid   = 1'b1;
            result_next.outcome = srfr_pkg::OUTCOME_FAIL;
          end
        end
        default: begin
        end
      endcase

      // Any session end drops the session and restarts the header hunt.
      if (result_next.valid) begin
        session_active_next = 1'b0;
        header_run_next     = 2'd0;
        frame_position_next = '0;
        frame_length_next   = '0;
        running_sum_next    = 8'd0;
        echo_match_next     = 1'b1;
        cap_id_next         = 8'd0;
        cap_err_next        = 8'd0;
        cap_p1_next         = 8'd0;
        cap_p2_next         = 8'd0;
      end
    end

    // Prefetch the echo byte for the position the next received byte will sit at.
    ram_raddr = (CW'(frame_position_next) < CW'(ECHO_DEPTH)) ? AW'(frame_position_next) : '0;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      servo_id       <= 8'd1;
      echo_length    <= '0;
      hdr0_ff        <= 1'b0;
      hdr1_ff        <= 1'b0;
      session_active <= 1'b0;
      header_run     <= 2'd0;
      frame_position <= '0;
      frame_length   <= '0;
      running_sum    <= 8'd0;
      echo_match     <= 1'b1;
      skipped_frames <= 2'd0;
      cap_id         <= 8'd0;
      cap_err        <= 8'd0;
      cap_p1         <= 8'd0;
      cap_p2         <= 8'd0;
      wanted_count   <= 2'd0;
      fwd_hit        <= 1'b0;
      result         <= '0;
    end else begin
      if (cfg_we) begin
        servo_id <= cfg_wdata;
      end
      echo_length    <= echo_length_next;
      hdr0_ff        <= hdr0_ff_next;
      hdr1_ff        <= hdr1_ff_next;
      session_active <= session_active_next;
      header_run     <= header_run_next;
      frame_position <= frame_position_next;
      frame_length   <= frame_length_next;
      running_sum    <= running_sum_next;
      echo_match     <= echo_match_next;
      skipped_frames <= skipped_frames_next;
      cap_id         <= cap_id_next;
      cap_err        <= cap_err_next;
      cap_p1         <= cap_p1_next;
      cap_p2         <= cap_p2_next;
      wanted_count   <= wanted_count_next;
      fwd_hit        <= ram_we && (ram_waddr == ram_raddr);
      result         <= result_next;
    end
  end

  // Bypass data for a write that lands on the address being read.
  always_ff @(posedge clk) begin
    fwd_data <= data_byte;
  end

endmodule

// ===== design/srfr_out.sv =====
// Output register with a skid stage between the parser and the result stream.
module srfr_out (
  input  logic              clk,
  input  logic              rst,
  input  srfr_pkg::result_t result,
  output logic              in_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic [0:0]        m_tuser
);

  srfr_pkg::result_t out_reg, skid_reg;
  logic              out_take;

  assign out_take = out_reg.valid && m_tready;
  // Input is held off while the skid stage is in use or may be needed by a result on its way.
  assign in_ready = !skid_reg.valid && !(out_reg.valid && result.valid);
  assign m_tvalid = out_reg.valid;
  assign m_tdata  = {out_reg.param_second, out_reg.param_first, out_reg.error_status};
  assign m_tuser  = out_reg.outcome;

  // Results fill the output register first and spill into the skid stage when it is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg  <= '0;
      skid_reg <= '0;
    end else if (skid_reg.valid) begin
      if (out_take) begin
        out_reg  <= skid_reg;
        skid_reg <= '0;
      end
    end else if (!out_reg.valid || out_take) begin
      out_reg <= result;
    end else if (result.valid) begin
      skid_reg <= result;
    end
  end

endmodule

// ===== design/servo_bus_reply_frame_receiver.sv =====
// Top level of the servo bus reply frame receiver.
//
// Items may follow back to back, one per clock cycle while s_tready is high;
// the parser updates its state and checks the current byte against the echo
// memory in the same cycle, because the echo byte for the next frame position
// is read from memory ahead of time, with a write to that same address bypassed.
// A result reaches the output stream through the parser's result register and
// then the output register, or the skid stage while the output register is held.
// s_tready drops while the skid stage holds a result, or while a result waits
// unread in the output register and another result is on its way to it.
// servo_id resets to 1 and may be written at any time the block is idle.
module servo_bus_reply_frame_receiver #(
  parameter int MAX_FRAME  = 20,
  parameter int ECHO_DEPTH = 16,
  parameter int MAX_SKIPS  = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // servo_id
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // data_byte[7:0], first_of_frame[8], param_count[10:9]
  input  logic [1:0]  s_tuser,       // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,       // error_status[7:0], param_first[15:8], param_second[23:16]
  output logic [0:0]  m_tuser        // outcome[0]
);

  srfr_pkg::result_t result;
  logic              accept;

  assign accept = s_tvalid && s_tready;

  // Frame parser with the echo memory.
  srfr_core #(
    .MAX_FRAME (MAX_FRAME),
    .ECHO_DEPTH(ECHO_DEPTH),
    .MAX_SKIPS (MAX_SKIPS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .item_valid    (accept),
    .operation     (s_tuser),
    .data_byte     (s_tdata[7:0]),
    .first_of_frame(s_tdata[8]),
    .param_count   (s_tdata[10:9]),
    .result        (result)
  );

  // Result stream with skid buffering.
  srfr_out u_out (
    .clk     (clk),
    .rst     (rst),
    .result  (result),
    .in_ready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
